/* hdl/sha1e_pkg.sv */
package sha1e_pkg;

  // Digest and block geometry
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned DIGEST_WORDS  = 5;
  localparam int unsigned SCHED_WORDS   = 16;
  localparam int unsigned ROUNDS        = 80;
  localparam int unsigned ROUND_W       = 7;
  localparam int unsigned BLOCK_POS_W   = 9;
  localparam int unsigned LEN_FIELD_W   = 64;
  localparam int unsigned LENGTH_BITS_DEF = 64;

  // Length field starts at this bit of the last block
  localparam logic [BLOCK_POS_W-1:0] PAD_LIMIT = 9'd448;
  localparam logic [BLOCK_POS_W-1:0] LAST_POS  = 9'd511;

  // Request codes
  localparam logic REQ_DATA   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // Initial hash value
  localparam logic [WORD_W-1:0] IV [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants, one per group of twenty rounds
  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  // Working variables a..e
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] e;
  } work_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

/* hdl/sha1e_in_if.sv */
interface sha1e_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic [3:0] valid_bits;

  modport source (output valid, output req_type, output data_byte, output valid_bits,
                  input ready);
  modport sink   (input valid, input req_type, input data_byte, input valid_bits,
                  output ready);
endinterface

/* hdl/sha1e_out_if.sv */
interface sha1e_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  modport source (output valid, output digest_word0, output digest_word1,
                  output digest_word2, output digest_word3, output digest_word4,
                  input ready);
  modport sink   (input valid, input digest_word0, input digest_word1,
                  input digest_word2, input digest_word3, input digest_word4,
                  output ready);
endinterface

/* hdl/sha1e_round.sv */
// One SHA-1 round: selects f and K by round group and forms the new a..e.
module sha1e_round (
  input  sha1e_pkg::work_t                         work_i,
  input  logic [sha1e_pkg::WORD_W-1:0]             w_i,
  input  logic [sha1e_pkg::ROUND_W-1:0]            round_i,
  output sha1e_pkg::work_t                         work_o
);

  logic [sha1e_pkg::WORD_W-1:0] f;
  logic [sha1e_pkg::WORD_W-1:0] k;
  logic [sha1e_pkg::WORD_W-1:0] t;

  // Round function and constant
  always_comb begin
    if (round_i < 7'd20) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = sha1e_pkg::K0;
    end else if (round_i < 7'd40) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1e_pkg::K1;
    end else if (round_i < 7'd60) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = sha1e_pkg::K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1e_pkg::K3;
    end
  end

  assign t = sha1e_pkg::rotl(work_i.a, 5) + f + work_i.e + k + w_i;

  // Shift the working variables
  always_comb begin
    work_o.a = t;
    work_o.b = work_i.a;
    work_o.c = sha1e_pkg::rotl(work_i.b, 30);
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

endmodule

/* hdl/sha1_hash_engine.sv */
// Channel   Dir  Payload                               Transfer
// in_ch     in   req_type, data_byte, valid_bits       valid & ready
// out_ch    out  digest_word0 .. digest_word4          valid & ready
//
// A data byte is accepted in idle, then inserted, again when it straddles a 32-bit word;
// a full 512-bit block adds all ROUNDS rounds on the shared round unit and the chaining add.
// A finish accepts, inserts the end bit, pads, compresses and emits; if the end bit
// fills a block or the length needs an extra pad block, that block compresses first.
// Reset is synchronous, active low; the engine starts a fresh message.
// in_ch is ready only in idle; emit stalls only while the previous digest still waits.
module sha1_hash_engine #(
  parameter int unsigned LENGTH_BITS = sha1e_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sha1e_in_if.sink    in_ch,
  sha1e_out_if.source out_ch
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_INSERT   = 6'b000010,
    ST_COMPRESS = 6'b000100,
    ST_UPDATE   = 6'b001000,
    ST_PAD      = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_t;

  localparam int unsigned WW = sha1e_pkg::WORD_W;
  localparam int unsigned NW = sha1e_pkg::SCHED_WORDS;
  localparam int unsigned DW = sha1e_pkg::DIGEST_WORDS;

  state_t                              state_r, state_nxt;
  logic [WW-1:0]                       chain_r [DW];
  logic [WW-1:0]                       chain_nxt [DW];
  sha1e_pkg::work_t                    work_r, work_nxt, work_rnd;
  logic [WW-1:0]                       sched_r [NW];
  logic [WW-1:0]                       sched_nxt [NW];
  logic [LENGTH_BITS-1:0]              bit_len_r, bit_len_nxt;
  logic [sha1e_pkg::ROUND_W-1:0]       round_r, round_nxt;
  logic [7:0]                          pend_data_r, pend_data_nxt;
  logic [3:0]                          pend_cnt_r, pend_cnt_nxt;
  logic                                fin_r, fin_nxt;
  logic                                extra_done_r, extra_done_nxt;
  logic                                len_done_r, len_done_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_load;
  logic [WW-1:0]                       digest_r [DW];

  logic [sha1e_pkg::BLOCK_POS_W-1:0]   pos;
  logic [3:0]                          wi;
  logic [4:0]                          off;
  logic [5:0]                          space;
  logic [3:0]                          take;
  logic [3:0]                          cnt_left;
  logic [WW-1:0]                       ins;
  logic                                fill;
  logic                                need_extra;
  logic [sha1e_pkg::LEN_FIELD_W-1:0]   len64;
  logic [3:0]                          n_in;
  logic [WW-1:0]                       w_new;

  // Bit placement in the block being filled
  assign pos        = bit_len_r[sha1e_pkg::BLOCK_POS_W-1:0];
  assign wi         = pos[8:5];
  assign off        = pos[4:0];
  assign space      = 6'd32 - {1'b0, off};
  assign take       = ({2'b00, pend_cnt_r} <= space) ? pend_cnt_r : space[3:0];
  assign cnt_left   = pend_cnt_r - take;
  assign ins        = {pend_data_r, 24'h000000} >> off;
  assign fill       = (wi == 4'hF) && (({1'b0, off} + {2'b00, take}) == 6'd32);
  assign need_extra = (pos >= sha1e_pkg::PAD_LIMIT) && (pos != sha1e_pkg::LAST_POS);
  assign len64      = sha1e_pkg::LEN_FIELD_W'(bit_len_r);
  assign n_in       = (in_ch.valid_bits > 4'd8) ? 4'd8 : in_ch.valid_bits;

  // Message schedule: next word from the fixed taps of the window
  assign w_new = sha1e_pkg::rotl(sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0], 1);

  sha1e_round u_round (
    .work_i  (work_r),
    .w_i     (sched_r[0]),
    .round_i (round_r),
    .work_o  (work_rnd)
  );

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.digest_word0 = digest_r[0];
  assign out_ch.digest_word1 = digest_r[1];
  assign out_ch.digest_word2 = digest_r[2];
  assign out_ch.digest_word3 = digest_r[3];
  assign out_ch.digest_word4 = digest_r[4];

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    chain_nxt      = chain_r;
    work_nxt       = work_r;
    sched_nxt      = sched_r;
    bit_len_nxt    = bit_len_r;
    round_nxt      = round_r;
    pend_data_nxt  = pend_data_r;
    pend_cnt_nxt   = pend_cnt_r;
    fin_nxt        = fin_r;
    extra_done_nxt = extra_done_r;
    len_done_nxt   = len_done_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_load       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.req_type == sha1e_pkg::REQ_FINISH) begin
            fin_nxt       = 1'b1;
            pend_data_nxt = 8'h80;
            pend_cnt_nxt  = 4'd1;
            state_nxt     = ST_INSERT;
          end else if (n_in != 4'd0) begin
            pend_data_nxt = in_ch.data_byte & ~(8'hFF >> n_in);
            pend_cnt_nxt  = n_in;
            state_nxt     = ST_INSERT;
          end
        end
      end

      ST_INSERT: begin
        for (int i = 0; i < NW; i++) begin
          if (wi == 4'(i)) sched_nxt[i] = sched_r[i] | ins;
        end
        pend_data_nxt = pend_data_r << take;
        pend_cnt_nxt  = cnt_left;
        // the end-of-message bit does not count toward the length
        if (!fin_r) bit_len_nxt = bit_len_r + LENGTH_BITS'(take);
        if (fill) begin
          work_nxt  = {chain_r[0], chain_r[1], chain_r[2], chain_r[3], chain_r[4]};
          round_nxt = '0;
          state_nxt = ST_COMPRESS;
        end else if (cnt_left != 4'd0) begin
          state_nxt = ST_INSERT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_COMPRESS: begin
        work_nxt = work_rnd;
        for (int i = 0; i < NW - 1; i++) sched_nxt[i] = sched_r[i+1];
        sched_nxt[NW-1] = w_new;
        round_nxt = round_r + 7'd1;
        if (round_r == 7'(sha1e_pkg::ROUNDS - 1)) begin
          round_nxt = '0;
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        chain_nxt[0] = chain_r[0] + work_r.a;
        chain_nxt[1] = chain_r[1] + work_r.b;
        chain_nxt[2] = chain_r[2] + work_r.c;
        chain_nxt[3] = chain_r[3] + work_r.d;
        chain_nxt[4] = chain_r[4] + work_r.e;
        for (int i = 0; i < NW; i++) sched_nxt[i] = '0;
        if (pend_cnt_r != 4'd0) begin
          state_nxt = ST_INSERT;
        end else if (fin_r) begin
          state_nxt = len_done_r ? ST_EMIT : ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_PAD: begin
        // no room for the length after the end bit: compress a block first
        if (need_extra && !extra_done_r) begin
          extra_done_nxt = 1'b1;
        end else begin
          sched_nxt[NW-2] = len64[63:32];
          sched_nxt[NW-1] = len64[31:0];
          len_done_nxt    = 1'b1;
        end
        work_nxt  = {chain_r[0], chain_r[1], chain_r[2], chain_r[3], chain_r[4]};
        round_nxt = '0;
        state_nxt = ST_COMPRESS;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load       = 1'b1;
          out_valid_nxt  = 1'b1;
          for (int i = 0; i < DW; i++) chain_nxt[i] = sha1e_pkg::IV[i];
          bit_len_nxt    = '0;
          fin_nxt        = 1'b0;
          extra_done_nxt = 1'b0;
          len_done_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      for (int i = 0; i < DW; i++) chain_r[i] <= sha1e_pkg::IV[i];
      for (int i = 0; i < NW; i++) sched_r[i] <= '0;
      bit_len_r    <= '0;
      round_r      <= '0;
      pend_cnt_r   <= '0;
      fin_r        <= 1'b0;
      extra_done_r <= 1'b0;
      len_done_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chain_r      <= chain_nxt;
      sched_r      <= sched_nxt;
      bit_len_r    <= bit_len_nxt;
      round_r      <= round_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      fin_r        <= fin_nxt;
      extra_done_r <= extra_done_nxt;
      len_done_r   <= len_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    pend_data_r <= pend_data_nxt;
    if (out_load) digest_r <= chain_r;
  end

endmodule
